// ===== sv/crc_checked_frame_deframer_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cfd_pkg.sv =====
// shared types, codes and the crc step for the frame deframer
package cfd_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // position of a byte inside a frame, after the sync word
    localparam logic [3:0] FP_SRC_TYPE    = 4'd0;
    localparam logic [3:0] FP_DST_TYPE    = 4'd1;
    localparam logic [3:0] FP_SRC_ADDR_LO = 4'd2;
    localparam logic [3:0] FP_SRC_ADDR_HI = 4'd3;
    localparam logic [3:0] FP_DST_ADDR_LO = 4'd4;
    localparam logic [3:0] FP_DST_ADDR_HI = 4'd5;
    localparam logic [3:0] FP_FUNC        = 4'd6;
    localparam logic [3:0] FP_LEN_LO      = 4'd7;
    localparam logic [3:0] FP_LEN_HI      = 4'd8;
    localparam logic [3:0] FP_PAYLOAD     = 4'd9;
    localparam logic [3:0] FP_CRC_LO      = 4'd10;
    localparam logic [3:0] FP_CRC_HI      = 4'd11;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  data;
        logic [15:0] index;
    } t_mid;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  source_type;
        logic [7:0]  dest_type;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
        logic [15:0] received_check;
        logic [15:0] computed_check;
    } t_result;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/cfd_fifo.sv =====
// small register queue used between the deframer stages
module cfd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/cfd_front.sv =====
// front stage: sync hunt and frame position tracking, tags each frame byte
module cfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_rx_byte,
    output logic            o_full,
    input  logic            i_mid_full,
    output logic            o_mid_push,
    output cfd_pkg::t_mid   o_mid_item
);

    localparam logic [7:0] SYNC_A = 8'hEB;
    localparam logic [7:0] SYNC_B = 8'h90;

    localparam logic [2:0] SYNC_NONE   = 3'd0;
    localparam logic [2:0] SYNC_GOT1   = 3'd1;
    localparam logic [2:0] SYNC_GOT2   = 3'd2;
    localparam logic [2:0] SYNC_GOT3   = 3'd3;
    localparam logic [2:0] SYNC_LOCKED = 3'd4;

    logic [2:0]  r_sync, n_sync;
    logic [3:0]  r_fpos, n_fpos;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic [15:0] w_count_inc;
    logic [15:0] w_length_full;
    logic        w_accept;
    logic        w_locked;

    assign o_full        = i_mid_full;
    assign w_accept      = i_push && !i_mid_full;
    assign w_locked      = (r_sync == SYNC_LOCKED);
    assign w_count_inc   = r_count + 16'd1;
    assign w_length_full = {i_rx_byte, r_length[7:0]};

    assign o_mid_push       = w_accept && w_locked && (r_fpos <= cfd_pkg::FP_CRC_HI);
    assign o_mid_item.op    = r_fpos;
    assign o_mid_item.data  = i_rx_byte;
    assign o_mid_item.index = r_count;

    always_comb begin
        n_sync   = r_sync;
        n_fpos   = r_fpos;
        n_length = r_length;
        n_count  = r_count;
        if (w_accept) begin
            if (!w_locked) begin
                // keep the longest sync prefix that ends here
                case (r_sync)
                    SYNC_NONE: n_sync = (i_rx_byte == SYNC_A) ? SYNC_GOT1 : SYNC_NONE;
                    SYNC_GOT1: begin
                        n_sync = (i_rx_byte == SYNC_B) ? SYNC_GOT2 :
                                 (i_rx_byte == SYNC_A) ? SYNC_GOT1 : SYNC_NONE;
                    end
                    SYNC_GOT2: n_sync = (i_rx_byte == SYNC_A) ? SYNC_GOT3 : SYNC_NONE;
                    SYNC_GOT3: begin
                        n_sync = (i_rx_byte == SYNC_B) ? SYNC_LOCKED :
                                 (i_rx_byte == SYNC_A) ? SYNC_GOT1 : SYNC_NONE;
                    end
                    default:   n_sync = SYNC_NONE;
                endcase
                if (n_sync == SYNC_LOCKED) begin
                    n_fpos  = cfd_pkg::FP_SRC_TYPE;
                    n_count = '0;
                end
            end else begin
                case (r_fpos)
                    cfd_pkg::FP_SRC_TYPE,
                    cfd_pkg::FP_DST_TYPE,
                    cfd_pkg::FP_SRC_ADDR_LO,
                    cfd_pkg::FP_SRC_ADDR_HI,
                    cfd_pkg::FP_DST_ADDR_LO,
                    cfd_pkg::FP_DST_ADDR_HI,
                    cfd_pkg::FP_FUNC: begin
                        n_fpos = r_fpos + 4'd1;
                    end
                    cfd_pkg::FP_LEN_LO: begin
                        n_length = {8'h00, i_rx_byte};
                        n_fpos   = cfd_pkg::FP_LEN_HI;
                    end
                    cfd_pkg::FP_LEN_HI: begin
                        n_length = w_length_full;
                        n_count  = '0;
                        // empty payload goes straight to the crc bytes
                        n_fpos   = (w_length_full == 16'd0) ? cfd_pkg::FP_CRC_LO
                                                            : cfd_pkg::FP_PAYLOAD;
                    end
                    cfd_pkg::FP_PAYLOAD: begin
                        n_count = w_count_inc;
                        if (w_count_inc == r_length) begin
                            n_fpos = cfd_pkg::FP_CRC_LO;
                        end
                    end
                    cfd_pkg::FP_CRC_LO: begin
                        n_fpos = cfd_pkg::FP_CRC_HI;
                    end
                    default: begin
                        n_sync = SYNC_NONE;
                        n_fpos = cfd_pkg::FP_SRC_TYPE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_NONE;
            r_fpos <= cfd_pkg::FP_SRC_TYPE;
        end else begin
            r_sync <= n_sync;
            r_fpos <= n_fpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_length <= n_length;
        r_count  <= n_count;
    end

`include "crc_checked_frame_deframer_assert.svh"

    `CFD_ASSERT_NOW(a_fpos_range, w_locked, r_fpos <= cfd_pkg::FP_CRC_HI, "frame position out of range")
    `CFD_ASSERT_NOW(a_payload_count, w_locked && (r_fpos == cfd_pkg::FP_PAYLOAD), r_count < r_length, "payload count past length")

endmodule

// ===== sv/cfd_back.sv =====
// back stage: crc, header capture and result forming into the output queue
module cfd_back #(
    parameter int OUT_DEPTH = cfd_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mid_empty,
    input  cfd_pkg::t_mid     i_mid_item,
    output logic              o_mid_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output cfd_pkg::t_result  o_result
);

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_src_type, n_src_type;
    logic [7:0]  r_dst_type, n_dst_type;
    logic [15:0] r_src_addr, n_src_addr;
    logic [15:0] r_dst_addr, n_dst_addr;
    logic [7:0]  r_func, n_func;
    logic [15:0] r_length, n_length;
    logic [7:0]  r_check_lo, n_check_lo;

    logic              w_out_full;
    logic              w_res_push;
    cfd_pkg::t_result  w_res;
    logic [15:0]       w_crc_base;
    logic [15:0]       w_crc_upd;
    logic [15:0]       w_rx_check;

    assign o_mid_pop  = !i_mid_empty && !w_out_full;
    // first header byte starts a fresh crc
    assign w_crc_base = (i_mid_item.op == cfd_pkg::FP_SRC_TYPE) ? cfd_pkg::CRC_INIT : r_crc;
    assign w_crc_upd  = cfd_pkg::crc16_byte(w_crc_base, i_mid_item.data);
    assign w_rx_check = {i_mid_item.data, r_check_lo};

    always_comb begin
        n_crc      = r_crc;
        n_src_type = r_src_type;
        n_dst_type = r_dst_type;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_func     = r_func;
        n_length   = r_length;
        n_check_lo = r_check_lo;
        w_res_push = 1'b0;
        w_res      = '0;
        if (o_mid_pop) begin
            if ((i_mid_item.op <= cfd_pkg::FP_LEN_HI) || (i_mid_item.op == cfd_pkg::FP_PAYLOAD)) begin
                n_crc = w_crc_upd;
            end
            case (i_mid_item.op)
                cfd_pkg::FP_SRC_TYPE:    n_src_type = i_mid_item.data;
                cfd_pkg::FP_DST_TYPE:    n_dst_type = i_mid_item.data;
                cfd_pkg::FP_SRC_ADDR_LO: n_src_addr = {8'h00, i_mid_item.data};
                cfd_pkg::FP_SRC_ADDR_HI: n_src_addr = {i_mid_item.data, r_src_addr[7:0]};
                cfd_pkg::FP_DST_ADDR_LO: n_dst_addr = {8'h00, i_mid_item.data};
                cfd_pkg::FP_DST_ADDR_HI: n_dst_addr = {i_mid_item.data, r_dst_addr[7:0]};
                cfd_pkg::FP_FUNC:        n_func     = i_mid_item.data;
                cfd_pkg::FP_LEN_LO:      n_length   = {8'h00, i_mid_item.data};
                cfd_pkg::FP_LEN_HI:      n_length   = {i_mid_item.data, r_length[7:0]};
                cfd_pkg::FP_PAYLOAD: begin
                    w_res_push          = 1'b1;
                    w_res.kind          = cfd_pkg::KIND_PAYLOAD;
                    w_res.payload_byte  = i_mid_item.data;
                    w_res.payload_index = i_mid_item.index;
                end
                cfd_pkg::FP_CRC_LO:      n_check_lo = i_mid_item.data;
                cfd_pkg::FP_CRC_HI: begin
                    w_res_push           = 1'b1;
                    w_res.kind           = (w_rx_check == r_crc) ? cfd_pkg::KIND_GOOD
                                                                 : cfd_pkg::KIND_BAD;
                    w_res.received_check = w_rx_check;
                    w_res.computed_check = r_crc;
                end
                default: begin
                    w_res_push = 1'b0;
                end
            endcase
            w_res.source_type    = r_src_type;
            w_res.dest_type      = r_dst_type;
            w_res.source_address = r_src_addr;
            w_res.dest_address   = r_dst_addr;
            w_res.function_code  = r_func;
            w_res.payload_length = r_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc      <= n_crc;
        r_src_type <= n_src_type;
        r_dst_type <= n_dst_type;
        r_src_addr <= n_src_addr;
        r_dst_addr <= n_dst_addr;
        r_func     <= n_func;
        r_length   <= n_length;
        r_check_lo <= n_check_lo;
    end

    cfd_fifo #(
        .WIDTH ($bits(cfd_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_result)
    );

`include "crc_checked_frame_deframer_assert.svh"

    `CFD_ASSERT_NEXT(a_status_queued, o_mid_pop && (i_mid_item.op == cfd_pkg::FP_CRC_HI), !o_empty, "frame status not queued")
    `CFD_ASSERT_NOW(a_kind_valid, !o_empty, o_result.kind != 2'd3, "result kind undefined")

endmodule

// ===== sv/crc_checked_frame_deframer.sv =====
// top level of the sync word frame deframer with crc-16 check
//
// Bytes enter through a queue-like port: a byte is taken at a clock edge
// with push high and full low. Results leave the same way: while empty is
// low the oldest result sits on the o_ ports, and pop takes it.
// The front stage hunts for EB 90 EB 90 and tags each frame byte with its
// position; a short queue of MID_DEPTH entries carries tagged bytes to the
// back stage, which runs the crc, holds the header and forms results into
// an output queue of OUT_DEPTH entries.
// A payload byte or frame status passes the middle and output queues.
// One byte per cycle is taken steadily while pop keeps up.
// Bytes spent hunting for sync never enter the queues.
// When pop stays low the output queue fills, the back stage holds, and
// full rises once the middle queue is full too; nothing is dropped.
// Synchronous active-low reset empties both queues and restarts the hunt;
// no result is pending after reset. An unfinished frame just waits.
module crc_checked_frame_deframer #(
    parameter int MID_DEPTH = cfd_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = cfd_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_source_type,
    output logic [7:0]  o_dest_type,
    output logic [15:0] o_source_address,
    output logic [15:0] o_dest_address,
    output logic [7:0]  o_function_code,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_received_check,
    output logic [15:0] o_computed_check
);

    logic              w_mid_push;
    logic              w_mid_full;
    logic              w_mid_empty;
    logic              w_mid_pop;
    cfd_pkg::t_mid     w_mid_in;
    cfd_pkg::t_mid     w_mid_out;
    cfd_pkg::t_result  w_result;

    cfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .o_full     (full),
        .i_mid_full (w_mid_full),
        .o_mid_push (w_mid_push),
        .o_mid_item (w_mid_in)
    );

    cfd_fifo #(
        .WIDTH ($bits(cfd_pkg::t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_mid_out)
    );

    cfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_item  (w_mid_out),
        .o_mid_pop   (w_mid_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (w_result)
    );

    assign o_kind           = w_result.kind;
    assign o_payload_byte   = w_result.payload_byte;
    assign o_payload_index  = w_result.payload_index;
    assign o_source_type    = w_result.source_type;
    assign o_dest_type      = w_result.dest_type;
    assign o_source_address = w_result.source_address;
    assign o_dest_address   = w_result.dest_address;
    assign o_function_code  = w_result.function_code;
    assign o_payload_length = w_result.payload_length;
    assign o_received_check = w_result.received_check;
    assign o_computed_check = w_result.computed_check;

endmodule
